>>> hw/rtl/kmt_pkg.sv
package kmt_pkg;

    localparam int MAX_HELD     = 8;
    localparam int CODE_W       = 16;
    localparam int CNT_W        = $clog2(MAX_HELD + 1);
    localparam int IDX_W        = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int TALLY_W      = 8;
    localparam int HELD_COUNT_W = 4;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    localparam logic [APB_ADDR_W-3:0] REG_LOCK_KEY_CODE = '0;

    typedef enum logic [1:0] {
        OP_ORDINARY = 2'd0,
        OP_SHIFT    = 2'd1,
        OP_LATCH    = 2'd2,
        OP_LOCK     = 2'd3
    } op_t;

    typedef struct packed {
        op_t               operation;
        logic              pressed;
        logic [CODE_W-1:0] scan_code;
    } in_item_t;

    typedef struct packed {
        logic                    modifier_active;
        logic                    lock_on;
        logic                    latch_on;
        logic [HELD_COUNT_W-1:0] held_count;
    } out_item_t;

    typedef struct packed {
        logic              down;
        logic [CODE_W-1:0] code;
        logic              keep_total;
    } list_cmd_t;

    typedef struct packed {
        logic             hit;
        logic             appended;
        logic [CNT_W-1:0] total;
    } list_rsp_t;

endpackage

>>> hw/rtl/kmt_cfg_regs.sv
module kmt_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kmt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [kmt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [kmt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [kmt_pkg::CODE_W-1:0]       lock_key_code
);
    import kmt_pkg::*;

    logic [CODE_W-1:0]       lock_key_code_reg;
    logic [APB_ADDR_W-3:0]   reg_sel;

    assign reg_sel       = paddr[APB_ADDR_W-1:2];
    assign pready        = 1'b1;
    assign lock_key_code = lock_key_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_key_code_reg <= '0;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_LOCK_KEY_CODE))
        begin
            lock_key_code_reg <= pwdata[CODE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_LOCK_KEY_CODE:
            begin
                prdata = APB_DATA_W'(lock_key_code_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/kmt_held_list.sv
module kmt_held_list (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  kmt_pkg::list_cmd_t  cmd,
    output logic                done,
    output kmt_pkg::list_rsp_t  rsp
);
    import kmt_pkg::*;

    typedef enum logic [1:0] {
        L_IDLE,
        L_SCAN,
        L_SHIFT
    } list_state_t;

    list_state_t       state_reg, state_next;
    list_cmd_t         cmd_reg, cmd_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              hit_reg, hit_next;
    logic              appended_reg, appended_next;
    logic              done_reg, done_next;

    logic [CODE_W-1:0] held_codes [MAX_HELD];

    logic [CNT_W-1:0]  idx_plus;
    logic [IDX_W-1:0]  rd_idx;
    logic [CODE_W-1:0] rd_code;
    logic              match;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [CODE_W-1:0] wr_data;

    assign idx_plus = idx_reg + CNT_W'(1);
    assign rd_idx   = (state_reg == L_SHIFT) ? idx_plus[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign rd_code  = held_codes[rd_idx];
    assign match    = (rd_code == cmd_reg.code);

    assign done         = done_reg;
    assign rsp.hit      = hit_reg;
    assign rsp.appended = appended_reg;
    assign rsp.total    = total_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        hit_next      = hit_reg;
        appended_next = appended_reg;
        done_next     = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = idx_reg[IDX_W-1:0];
        wr_data       = cmd_reg.code;

        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd;
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    appended_next = 1'b0;
                    state_next    = L_SCAN;
                end
            end
            L_SCAN:
            begin
                if (idx_reg == total_reg)
                begin
                    if (cmd_reg.down && !hit_reg && (total_reg < CNT_W'(MAX_HELD)))
                    begin
                        wr_en         = 1'b1;
                        wr_idx        = total_reg[IDX_W-1:0];
                        total_next    = total_reg + CNT_W'(1);
                        appended_next = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
                else if (match && !cmd_reg.down)
                begin
                    hit_next   = 1'b1;
                    state_next = L_SHIFT;
                end
                else
                begin
                    if (match)
                    begin
                        hit_next = 1'b1;
                    end
                    idx_next = idx_plus;
                end
            end
            L_SHIFT:
            begin
                if (idx_plus >= total_reg)
                begin
                    if (!cmd_reg.keep_total)
                    begin
                        total_next = total_reg - CNT_W'(1);
                    end
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_idx   = idx_reg[IDX_W-1:0];
                    wr_data  = rd_code;
                    idx_next = idx_plus;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= L_IDLE;
            cmd_reg      <= '0;
            idx_reg      <= '0;
            total_reg    <= '0;
            hit_reg      <= 1'b0;
            appended_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            idx_reg      <= idx_next;
            total_reg    <= total_next;
            hit_reg      <= hit_next;
            appended_reg <= appended_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            held_codes[wr_idx] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/keyboard_modifier_tracker_top.sv
// Tracks keyboard modifier state (held shift keys, a one-shot latch and a lock) from key-event
// transactions and returns one status transaction per event. The block takes one event at a
// time. Ordinary, latch and lock events pass through the execute and finish states before
// out_valid rises. Shift events walk the held-code list one entry per cycle through a single
// compare port. A release stops the walk at the matching entry and compacts the rest of the
// list from there, so a shift event takes longer the more codes are held when it arrives. A new
// event is accepted while the previous result still waits to be taken. The lock key code
// register sits at byte address 0.
module keyboard_modifier_tracker_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  kmt_pkg::in_item_t                in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output kmt_pkg::out_item_t               out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kmt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [kmt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [kmt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import kmt_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_EXEC,
        T_LIST,
        T_FINISH
    } top_state_t;

    top_state_t          state_reg, state_next;
    in_item_t            item_reg, item_next;
    logic                latch_reg, latch_next;
    logic                let_go_reg, let_go_next;
    logic [TALLY_W-1:0]  tally_reg, tally_next;
    logic                lock_reg, lock_next;
    logic                active_reg, active_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    logic [CODE_W-1:0]   lock_key_code;
    logic                accept;
    logic                list_start;
    list_cmd_t           list_cmd;
    logic                list_done;
    list_rsp_t           list_rsp;
    logic                total_nz;

    kmt_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .lock_key_code (lock_key_code)
    );

    assign in_ready            = (state_reg == T_IDLE);
    assign accept              = in_valid && in_ready;
    assign list_start          = accept && (in_item.operation == OP_SHIFT);
    assign list_cmd.down       = in_item.pressed;
    assign list_cmd.code       = in_item.scan_code;
    assign list_cmd.keep_total = lock_reg || latch_reg;

    kmt_held_list u_list (
        .clk   (clk),
        .rst_n (rst_n),
        .start (list_start),
        .cmd   (list_cmd),
        .done  (list_done),
        .rsp   (list_rsp)
    );

    assign total_nz  = (list_rsp.total != '0);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        latch_next     = latch_reg;
        let_go_next    = let_go_reg;
        tally_next     = tally_reg;
        lock_next      = lock_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    item_next  = in_item;
                    state_next = (in_item.operation == OP_SHIFT) ? T_LIST : T_EXEC;
                end
            end
            T_EXEC:
            begin
                unique case (item_reg.operation)
                    OP_ORDINARY:
                    begin
                        if (latch_reg && !item_reg.pressed)
                        begin
                            if (!let_go_reg)
                            begin
                                if (tally_reg != TALLY_MAX)
                                begin
                                    tally_next = tally_reg + TALLY_W'(1);
                                end
                            end
                            else
                            begin
                                latch_next  = 1'b0;
                                active_next = total_nz;
                            end
                        end
                    end
                    OP_LATCH:
                    begin
                        lock_next = 1'b0;
                        if (item_reg.pressed)
                        begin
                            if (!latch_reg || let_go_reg)
                            begin
                                latch_next  = 1'b1;
                                let_go_next = 1'b0;
                                tally_next  = '0;
                            end
                            active_next = 1'b1;
                        end
                        else
                        begin
                            let_go_next = 1'b1;
                            latch_next  = (tally_reg == '0);
                            active_next = (tally_reg == '0) || total_nz;
                        end
                    end
                    OP_LOCK:
                    begin
                        if (item_reg.pressed && (item_reg.scan_code != lock_key_code))
                        begin
                            lock_next   = !lock_reg;
                            active_next = !lock_reg || latch_reg || total_nz;
                        end
                    end
                    OP_SHIFT:
                    begin
                        active_next = active_reg;
                    end
                    default:
                    begin
                        active_next = active_reg;
                    end
                endcase
                state_next = T_FINISH;
            end
            T_LIST:
            begin
                if (list_done)
                begin
                    if (item_reg.pressed)
                    begin
                        if (list_rsp.hit || list_rsp.appended)
                        begin
                            active_next = 1'b1;
                        end
                    end
                    else if (list_rsp.hit)
                    begin
                        active_next = lock_reg || latch_reg || total_nz;
                    end
                    state_next = T_FINISH;
                end
            end
            T_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                 = 1'b1;
                    out_item_next.modifier_active  = active_reg;
                    out_item_next.lock_on          = lock_reg;
                    out_item_next.latch_on         = latch_reg;
                    out_item_next.held_count       = HELD_COUNT_W'(list_rsp.total);
                    state_next                     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            item_reg      <= '0;
            latch_reg     <= 1'b0;
            let_go_reg    <= 1'b0;
            tally_reg     <= '0;
            lock_reg      <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            latch_reg     <= latch_next;
            let_go_reg    <= let_go_next;
            tally_reg     <= tally_next;
            lock_reg      <= lock_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

endmodule

>>> hw/rtl/kmt_checker.sv
module kmt_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  kmt_pkg::in_item_t                in_item,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  kmt_pkg::out_item_t               out_item
);
    import kmt_pkg::*;

    logic accept;

    assign accept = in_valid && in_ready;

    // The block holds one event at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while an event is still being processed");

    // A result never appears in the cycle right after its event is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !$rose(out_valid))
        else $error("result appeared too early after an accepted transaction");

    // A set latch always counts as an active modifier.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.latch_on) |-> out_item.modifier_active)
        else $error("latch reported on without an active modifier");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("stalled result transaction changed");

endmodule

bind keyboard_modifier_tracker_top kmt_checker u_kmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

>>> verif/tb_keyboard_modifier_tracker_top.sv
`timescale 1ns / 100ps

module tb_keyboard_modifier_tracker_top;

    import kmt_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 2 * MAX_HELD + 8;
    localparam int POOL_SIZE     = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted block state.
    logic [CODE_W-1:0]  key_list [MAX_HELD];
    int                 key_total        = 0;
    logic               latch_set        = 1'b0;
    logic               latch_freed      = 1'b0;
    logic [TALLY_W-1:0] latch_taps       = '0;
    logic               lock_set         = 1'b0;
    logic               modifier_flag    = 1'b0;
    logic [CODE_W-1:0]  lock_exempt_code = '0;

    out_item_t          expected_status [$];
    logic [CODE_W-1:0]  key_pool [POOL_SIZE];
    int                 events_sent        = 0;
    int                 error_count        = 0;
    int                 cycle_count        = 0;
    int                 sender_idle_pct    = 0;
    int                 receiver_stall_pct = 0;
    int                 hold_off_cycles    = 0;

    keyboard_modifier_tracker_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("keyboard_modifier_tracker_top regression: fail");
            $finish;
        end
    end

    function automatic out_item_t next_modifier_status(input in_item_t ev);
        out_item_t status;
        int        n;
        logic      seen;
        seen = 1'b0;
        n    = key_total;
        case (ev.operation)
            OP_ORDINARY:
            begin
                if (latch_set && !ev.pressed)
                begin
                    if (!latch_freed)
                    begin
                        if (latch_taps != TALLY_MAX)
                            latch_taps = latch_taps + 1'b1;
                    end
                    else
                    begin
                        latch_set     = 1'b0;
                        modifier_flag = (key_total != 0);
                    end
                end
            end
            OP_SHIFT:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (key_list[i] == ev.scan_code)
                    begin
                        if (!ev.pressed)
                        begin
                            for (int k = i + 1; k < n; k++)
                                key_list[k - 1] = key_list[k];
                            // A held lock or latch keeps the count, leaving the last slot stale.
                            if (lock_set || latch_set)
                                modifier_flag = 1'b1;
                            else
                            begin
                                key_total--;
                                modifier_flag = (key_total != 0);
                            end
                            break;
                        end
                        seen          = 1'b1;
                        modifier_flag = 1'b1;
                    end
                end
                if (ev.pressed && !seen && key_total < MAX_HELD)
                begin
                    key_list[key_total] = ev.scan_code;
                    key_total++;
                    modifier_flag = 1'b1;
                end
            end
            OP_LATCH:
            begin
                lock_set = 1'b0;
                if (ev.pressed)
                begin
                    if (!latch_set || latch_freed)
                    begin
                        latch_set   = 1'b1;
                        latch_freed = 1'b0;
                        latch_taps  = '0;
                    end
                end
                else
                begin
                    latch_freed = 1'b1;
                    latch_set   = (latch_taps == 0);
                end
                modifier_flag = latch_set || (key_total != 0);
            end
            OP_LOCK:
            begin
                if (ev.pressed && ev.scan_code != lock_exempt_code)
                begin
                    lock_set      = !lock_set;
                    modifier_flag = lock_set || latch_set || (key_total != 0);
                end
            end
        endcase
        status.modifier_active = modifier_flag;
        status.lock_on         = lock_set;
        status.latch_on        = latch_set;
        status.held_count      = key_total[HELD_COUNT_W-1:0];
        return status;
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        return CODE_W'($urandom);
    endfunction

    function automatic logic [CODE_W-1:0] lock_code_choice();
        return ($urandom_range(99) < 40) ? lock_exempt_code : random_code();
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles--;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            out_item_t want;
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none actual %p", $time, out_item);
                error_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("modifier_active", want.modifier_active, out_item.modifier_active);
                check_field("lock_on", want.lock_on, out_item.lock_on);
                check_field("latch_on", want.latch_on, out_item.latch_on);
                check_field("held_count", want.held_count, out_item.held_count);
            end
        end
    end

    // All tasks start and end just after a falling edge.
    task automatic send_key(input op_t op, input logic pressed, input logic [CODE_W-1:0] code);
        in_item_t ev;
        ev.operation = op;
        ev.pressed   = pressed;
        ev.scan_code = code;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        do
            @(posedge clk);
        while (!in_ready);
        expected_status.push_back(next_modifier_status(ev));
        events_sent++;
        @(negedge clk);
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_lock_code(input logic [CODE_W-1:0] code);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LOCK_KEY_CODE, 2'b00};
        pwdata  <= APB_DATA_W'(code);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        lock_exempt_code = code;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA_W'(code))
        begin
            $display("%0t: lock_key_code readback mismatch, expected %0h actual %0h",
                     $time, code, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idling(input int idle_pct, input int stall_pct);
        @(posedge clk);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        @(negedge clk);
    endtask

    // Shift chords around a few typed keys, with occasional latch taps and lock presses.
    task automatic type_burst();
        int shifts;
        int taps;
        shifts = $urandom_range(0, MAX_HELD + 1);
        taps   = $urandom_range(1, 5);
        for (int i = 0; i < shifts; i++)
            send_key(OP_SHIFT, 1'b1, key_pool[$urandom_range(POOL_SIZE - 1)]);
        if ($urandom_range(2) == 0)
        begin
            send_key(OP_LATCH, 1'b1, random_code());
            if ($urandom_range(1) == 1)
                send_key(OP_LATCH, 1'b0, random_code());
        end
        if ($urandom_range(4) == 0)
            send_key(OP_LOCK, 1'b1, lock_code_choice());
        for (int i = 0; i < taps; i++)
        begin
            send_key(OP_ORDINARY, 1'b1, random_code());
            send_key(OP_ORDINARY, 1'b0, random_code());
            if ($urandom_range(5) == 0)
                send_key(OP_LATCH, 1'b0, random_code());
        end
        for (int i = 0; i <= shifts; i++)
            send_key(OP_SHIFT, 1'b0, key_pool[$urandom_range(POOL_SIZE - 1)]);
    endtask

    task automatic run_typing(input int count);
        int stop_at;
        stop_at = events_sent + count;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = random_code();
        while (events_sent < stop_at)
        begin
            if ($urandom_range(99) < 75)
                type_burst();
            else
                send_key(op_t'($urandom_range(3)), 1'($urandom_range(1)), lock_code_choice());
        end
    endtask

    task automatic test_directed_events();
        send_key(OP_ORDINARY, 1'b1, 16'h0000);
        send_key(OP_ORDINARY, 1'b0, 16'hFFFF);
        // The lock code resets to zero, so this press must not toggle.
        send_key(OP_LOCK, 1'b1, 16'h0000);
        send_key(OP_LOCK, 1'b1, 16'hFFFF);
        send_key(OP_LOCK, 1'b0, 16'h1234);
        send_key(OP_SHIFT, 1'b1, 16'h0000);
        send_key(OP_SHIFT, 1'b1, 16'hFFFF);
        send_key(OP_SHIFT, 1'b1, 16'h0000);
        send_key(OP_SHIFT, 1'b0, 16'h0000);
        send_key(OP_LATCH, 1'b1, 16'h5555);
        send_key(OP_LATCH, 1'b1, 16'hAAAA);
        send_key(OP_ORDINARY, 1'b0, 16'h0042);
        send_key(OP_LATCH, 1'b0, 16'h0000);
        send_key(OP_SHIFT, 1'b0, 16'hFFFF);
        send_key(OP_SHIFT, 1'b0, 16'hFFFF);
        send_key(OP_SHIFT, 1'b0, 16'hAAAA);
        send_key(OP_LATCH, 1'b1, 16'h0000);
        send_key(OP_LATCH, 1'b0, 16'h0000);
        send_key(OP_ORDINARY, 1'b0, 16'h0001);
        // Fill the list, then one more press that must be ignored.
        for (int i = 0; i <= MAX_HELD; i++)
            send_key(OP_SHIFT, 1'b1, CODE_W'(16'h0101 * (i + 1)));
        send_key(OP_SHIFT, 1'b0, 16'h0303);
        wait_until_idle();
    endtask

    task automatic test_lock_key_code();
        write_lock_code(16'hFFFF);
        send_key(OP_LOCK, 1'b1, 16'hFFFF);
        send_key(OP_LOCK, 1'b1, 16'h7FFF);
        send_key(OP_LOCK, 1'b0, 16'h7FFF);
        send_key(OP_LOCK, 1'b1, 16'h0000);
        send_key(OP_LOCK, 1'b1, 16'hFFFF);
        wait_until_idle();
        write_lock_code(16'h0000);
        send_key(OP_LOCK, 1'b1, 16'h0000);
        send_key(OP_LOCK, 1'b1, 16'h8000);
        wait_until_idle();
    endtask

    // A wrapping tally would read zero after 256 releases and keep the latch.
    task automatic test_tally_saturation();
        set_idling(11, 11);
        send_key(OP_LATCH, 1'b0, random_code());
        send_key(OP_LATCH, 1'b1, random_code());
        for (int i = 0; i < 256; i++)
            send_key(OP_ORDINARY, 1'b0, random_code());
        send_key(OP_LATCH, 1'b0, random_code());
        send_key(OP_ORDINARY, 1'b0, random_code());
        wait_until_idle();
        set_idling(0, 0);
    endtask

    task automatic test_random_typing();
        int idle_mix  [4] = '{0, 81, 0, 11};
        int stall_mix [4] = '{0, 0, 81, 11};
        for (int p = 0; p < 4; p++)
        begin
            wait_until_idle();
            if (p == 1)
                write_lock_code(16'h0000);
            else if (p == 2)
                write_lock_code(16'hFFFF);
            else
                write_lock_code(random_code());
            set_idling(idle_mix[p], stall_mix[p]);
            run_typing(320);
        end
        wait_until_idle();
        set_idling(0, 0);
    endtask

    task automatic test_output_backpressure();
        @(posedge clk);
        hold_off_cycles = 400;
        @(negedge clk);
        run_typing(40);
        wait_until_idle();
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_events();
        test_lock_key_code();
        test_tally_saturation();
        test_random_typing();
        test_output_backpressure();
        if (error_count == 0)
            $display("keyboard_modifier_tracker_top regression: pass");
        else
            $display("keyboard_modifier_tracker_top regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/kmt_pkg.sv
hw/rtl/kmt_cfg_regs.sv
hw/rtl/kmt_held_list.sv
hw/rtl/keyboard_modifier_tracker_top.sv
hw/rtl/kmt_checker.sv
verif/tb_keyboard_modifier_tracker_top.sv
